@@ sv/brms_pkg.sv @@
// Shared types, codes, constants and decode functions of the banked register file.
`timescale 1ns / 1ps

package brms_pkg;

  // Item kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_SWITCH  = 3'd2;
  localparam logic [2:0] KIND_EXC     = 3'd3;
  localparam logic [2:0] KIND_WSTATUS = 3'd4;
  localparam logic [2:0] KIND_RSAVED  = 3'd5;
  localparam logic [2:0] KIND_WSAVED  = 3'd6;

  // Exception codes
  localparam logic [2:0] EXC_RESET    = 3'd0;
  localparam logic [2:0] EXC_UNDEF    = 3'd1;
  localparam logic [2:0] EXC_SWI      = 3'd2;
  localparam logic [2:0] EXC_PABORT   = 3'd3;
  localparam logic [2:0] EXC_DABORT   = 3'd4;
  localparam logic [2:0] EXC_IRQ      = 3'd5;
  localparam logic [2:0] EXC_FIQ      = 3'd6;

  // Mode numbers
  localparam logic [4:0] MODE_USR26   = 5'd0;
  localparam logic [4:0] MODE_FIQ26   = 5'd1;
  localparam logic [4:0] MODE_IRQ26   = 5'd2;
  localparam logic [4:0] MODE_SVC26   = 5'd3;
  localparam logic [4:0] MODE_USR32   = 5'd16;
  localparam logic [4:0] MODE_FIQ32   = 5'd17;
  localparam logic [4:0] MODE_IRQ32   = 5'd18;
  localparam logic [4:0] MODE_SVC32   = 5'd19;
  localparam logic [4:0] MODE_ABT32   = 5'd23;
  localparam logic [4:0] MODE_UND32   = 5'd27;

  // Banks
  localparam logic [2:0] BANK_USR     = 3'd0;
  localparam logic [2:0] BANK_FIQ     = 3'd1;
  localparam logic [2:0] BANK_IRQ     = 3'd2;
  localparam logic [2:0] BANK_SVC     = 3'd3;
  localparam logic [2:0] BANK_ABT     = 3'd4;
  localparam logic [2:0] BANK_UND     = 3'd5;

  localparam logic [3:0]  PC_INDEX     = 4'd15;
  localparam logic [3:0]  LINK_INDEX   = 4'd14;
  localparam logic [31:0] USER_PC_MASK = 32'h0c00_0003;
  localparam int unsigned IRQ_OFF_BIT  = 7;
  localparam int unsigned FIQ_OFF_BIT  = 6;

  // Physical register store: r0-r7, user r8-r14, fiq r8-r14, r13/r14 of irq/svc/abt/und
  localparam int unsigned GPR_NUM  = 30;
  localparam int unsigned GPR_AW   = $clog2(GPR_NUM);
  localparam int unsigned SPSR_NUM = 5;
  localparam int unsigned SPSR_AW  = $clog2(SPSR_NUM);
  localparam logic [GPR_AW-1:0] FIQ_BASE_M8 = GPR_AW'(7);
  localparam logic [GPR_AW-1:0] STK_BASE    = GPR_AW'(22);

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  new_mode;
    logic [2:0]  exception_code;
  } brms_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] status_word;
    logic [4:0]  current_mode;
    logic [31:0] pc_mask;
    logic        wide_mode;
    logic        bad_mode;
  } brms_result_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] bank;
  } brms_bank_sel_t;

  // Architectural state seen by the execute logic
  typedef struct packed {
    logic [31:0] status;
    logic [2:0]  bank;
    logic [31:0] pc_mask;
    logic [31:0] pc;
  } brms_state_t;

  // Update command from execute logic to the register store
  typedef struct packed {
    logic              gpr_we;
    logic [GPR_AW-1:0] gpr_addr;
    logic [31:0]       gpr_data;
    logic               spsr_we;
    logic [SPSR_AW-1:0] spsr_addr;
    logic [31:0]        spsr_data;
    logic        pc_we;
    logic [31:0] pc_data;
    logic        ctl_we;
    logic [31:0] status;
    logic [2:0]  bank;
    logic [31:0] pc_mask;
  } brms_wr_t;

  function automatic brms_bank_sel_t bank_of_mode(input logic [4:0] mode);
    brms_bank_sel_t sel;
    sel.ok = 1'b1;
    case (mode)
      MODE_USR26, MODE_USR32: sel.bank = BANK_USR;
      MODE_FIQ26, MODE_FIQ32: sel.bank = BANK_FIQ;
      MODE_IRQ26, MODE_IRQ32: sel.bank = BANK_IRQ;
      MODE_SVC26, MODE_SVC32: sel.bank = BANK_SVC;
      MODE_ABT32:             sel.bank = BANK_ABT;
      MODE_UND32:             sel.bank = BANK_UND;
      default: begin
        sel.ok   = 1'b0;
        sel.bank = BANK_USR;
      end
    endcase
    return sel;
  endfunction

  // Unused bank codes behave as the user bank
  function automatic logic [2:0] active_bank(input logic [2:0] bank);
    return (bank > BANK_UND) ? BANK_USR : bank;
  endfunction

  // Physical slot of visible register idx (not r15) in bank b
  function automatic logic [GPR_AW-1:0] gpr_slot(input logic [3:0] idx,
                                                 input logic [2:0] b);
    logic [2:0] stk;
    stk = {2'(b - BANK_IRQ), ~idx[0]};
    if (!idx[3]) begin
      return GPR_AW'(idx);
    end else if (b == BANK_FIQ) begin
      return FIQ_BASE_M8 + GPR_AW'(idx);
    end else if (idx < 4'd13 || b == BANK_USR) begin
      return GPR_AW'(idx);
    end else begin
      return STK_BASE + GPR_AW'(stk);
    end
  endfunction

  function automatic logic [4:0] exc_mode(input logic [2:0] code);
    case (code)
      EXC_RESET:  return MODE_SVC32;
      EXC_UNDEF:  return MODE_UND32;
      EXC_SWI:    return MODE_SVC32;
      EXC_PABORT: return MODE_ABT32;
      EXC_DABORT: return MODE_ABT32;
      EXC_IRQ:    return MODE_IRQ32;
      default:    return MODE_FIQ32;
    endcase
  endfunction

  function automatic logic [31:0] exc_vector(input logic [2:0] code);
    case (code)
      EXC_RESET:  return 32'h00 + 32'd8;
      EXC_UNDEF:  return 32'h04 + 32'd8;
      EXC_SWI:    return 32'h08 + 32'd8;
      EXC_PABORT: return 32'h0C + 32'd8;
      EXC_DABORT: return 32'h10 + 32'd8;
      EXC_IRQ:    return 32'h18 + 32'd8;
      default:    return 32'h1C + 32'd8;
    endcase
  endfunction

  // Link gets PC-4 for these entries, PC for the rest
  function automatic logic exc_minus4(input logic [2:0] code);
    return (code == EXC_UNDEF) || (code == EXC_SWI) || (code == EXC_PABORT);
  endfunction

  // These entries mask FIQ as well as IRQ
  function automatic logic exc_fiq_off(input logic [2:0] code);
    return (code == EXC_RESET) || (code == EXC_FIQ);
  endfunction

endpackage

@@ sv/brms_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transfer.
`timescale 1ns / 1ps

interface brms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/brms_bank.sv @@
// Register store: banked general registers, PC, status, saved status, bank and PC mask.
`timescale 1ns / 1ps

module brms_bank (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  brms_pkg::brms_wr_t                wr_i,
  input  logic [brms_pkg::GPR_AW-1:0]       gpr_raddr_i,
  input  logic [brms_pkg::SPSR_AW-1:0]      spsr_raddr_i,
  output logic [31:0]                       gpr_rdata_o,
  output logic [31:0]                       spsr_rdata_o,
  output brms_pkg::brms_state_t             state_o
);

  logic [31:0] gpr_q  [brms_pkg::GPR_NUM];
  logic [31:0] spsr_q [brms_pkg::SPSR_NUM];
  logic [31:0] pc_q;
  logic [31:0] status_q;
  logic [2:0]  bank_q;
  logic [31:0] pc_mask_q;

  // General registers: one write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < brms_pkg::GPR_NUM; i++) begin
        gpr_q[i] <= '0;
      end
    end else if (wr_i.gpr_we) begin
      gpr_q[wr_i.gpr_addr] <= wr_i.gpr_data;
    end
  end

  // Saved status slots of banks fiq..und
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < brms_pkg::SPSR_NUM; i++) begin
        spsr_q[i] <= '0;
      end
    end else if (wr_i.spsr_we) begin
      spsr_q[wr_i.spsr_addr] <= wr_i.spsr_data;
    end
  end

  // PC, status, bank and mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      status_q  <= '0;
      bank_q    <= brms_pkg::BANK_USR;
      pc_mask_q <= '0;
    end else begin
      if (wr_i.pc_we) begin
        pc_q <= wr_i.pc_data;
      end
      if (wr_i.ctl_we) begin
        status_q  <= wr_i.status;
        bank_q    <= wr_i.bank;
        pc_mask_q <= wr_i.pc_mask;
      end
    end
  end

  // Read ports
  assign gpr_rdata_o  = gpr_q[gpr_raddr_i];
  assign spsr_rdata_o = spsr_q[spsr_raddr_i];

  assign state_o.status  = status_q;
  assign state_o.bank    = bank_q;
  assign state_o.pc_mask = pc_mask_q;
  assign state_o.pc      = pc_q;

endmodule

@@ sv/brms_exec.sv @@
// Execute logic: decodes one item against the current state into updates and a result.
`timescale 1ns / 1ps

module brms_exec (
  input  logic                              go_i,
  input  brms_pkg::brms_item_t              item_i,
  input  brms_pkg::brms_state_t             state_i,
  input  logic [31:0]                       gpr_rdata_i,
  input  logic [31:0]                       spsr_rdata_i,
  output logic [brms_pkg::GPR_AW-1:0]       gpr_raddr_o,
  output logic [brms_pkg::SPSR_AW-1:0]      spsr_raddr_o,
  output brms_pkg::brms_wr_t                wr_o,
  output brms_pkg::brms_result_t            res_o
);

  logic [2:0]               act_bank;
  brms_pkg::brms_bank_sel_t sw_sel;
  brms_pkg::brms_bank_sel_t st_sel;
  logic [4:0]               em;
  brms_pkg::brms_bank_sel_t ex_sel;
  brms_pkg::brms_wr_t       wr;
  logic [31:0]              rd;
  logic                     bad;
  logic [31:0]              ex_status;

  assign act_bank = brms_pkg::active_bank(state_i.bank);
  assign sw_sel   = brms_pkg::bank_of_mode(item_i.new_mode);
  assign st_sel   = brms_pkg::bank_of_mode(item_i.write_data[4:0]);
  assign em       = brms_pkg::exc_mode(item_i.exception_code);
  assign ex_sel   = brms_pkg::bank_of_mode(em);

  // Status after exception entry: new mode, IRQ masked, and FIQ masked as well for reset and FIQ entries
  always_comb begin
    ex_status = {state_i.status[31:5], em};
    ex_status[brms_pkg::IRQ_OFF_BIT] = 1'b1;
    if (brms_pkg::exc_fiq_off(item_i.exception_code)) begin
      ex_status[brms_pkg::FIQ_OFF_BIT] = 1'b1;
    end
  end

  // Read addresses follow the active bank
  assign gpr_raddr_o  = brms_pkg::gpr_slot(item_i.reg_index, act_bank);
  assign spsr_raddr_o = (act_bank == brms_pkg::BANK_USR) ? '0
                        : brms_pkg::SPSR_AW'(act_bank - 3'd1);

  // Decode the item
  always_comb begin
    wr         = '0;
    wr.status  = state_i.status;
    wr.bank    = state_i.bank;
    wr.pc_mask = state_i.pc_mask;
    rd         = '0;
    bad        = 1'b0;
    case (item_i.kind)
      brms_pkg::KIND_READ: begin
        rd = (item_i.reg_index == brms_pkg::PC_INDEX) ? state_i.pc : gpr_rdata_i;
      end
      brms_pkg::KIND_WRITE: begin
        if (item_i.reg_index == brms_pkg::PC_INDEX) begin
          wr.pc_we   = 1'b1;
          wr.pc_data = item_i.write_data;
        end else begin
          wr.gpr_we   = 1'b1;
          wr.gpr_addr = gpr_raddr_o;
          wr.gpr_data = item_i.write_data;
        end
      end
      brms_pkg::KIND_SWITCH: begin
        if (!sw_sel.ok) begin
          bad = 1'b1;
        end else begin
          // save old status only on a real change into a privileged bank
          if (item_i.new_mode != state_i.status[4:0] && sw_sel.bank != brms_pkg::BANK_USR) begin
            wr.spsr_we   = 1'b1;
            wr.spsr_addr = brms_pkg::SPSR_AW'(sw_sel.bank - 3'd1);
            wr.spsr_data = state_i.status;
          end
          wr.bank    = sw_sel.bank;
          wr.pc_mask = (sw_sel.bank == brms_pkg::BANK_USR) ? brms_pkg::USER_PC_MASK : '0;
          wr.status  = {state_i.status[31:5], item_i.new_mode};
        end
      end
      brms_pkg::KIND_EXC: begin
        if (item_i.exception_code > brms_pkg::EXC_FIQ) begin
          bad = 1'b1;
        end else begin
          if (em != state_i.status[4:0]) begin
            wr.spsr_we   = 1'b1;
            wr.spsr_addr = brms_pkg::SPSR_AW'(ex_sel.bank - 3'd1);
            wr.spsr_data = state_i.status;
          end
          wr.bank    = ex_sel.bank;
          wr.pc_mask = '0;
          wr.status  = ex_status;
          // link register of the new bank
          wr.gpr_we   = 1'b1;
          wr.gpr_addr = brms_pkg::gpr_slot(brms_pkg::LINK_INDEX, ex_sel.bank);
          wr.gpr_data = brms_pkg::exc_minus4(item_i.exception_code)
                        ? state_i.pc - 32'd4 : state_i.pc;
          wr.pc_we    = 1'b1;
          wr.pc_data  = brms_pkg::exc_vector(item_i.exception_code);
        end
      end
      brms_pkg::KIND_WSTATUS: begin
        if (!st_sel.ok) begin
          // keep old mode bits
          wr.status = {item_i.write_data[31:5], state_i.status[4:0]};
          bad       = 1'b1;
        end else begin
          wr.status  = item_i.write_data;
          wr.bank    = st_sel.bank;
          wr.pc_mask = (st_sel.bank == brms_pkg::BANK_USR) ? brms_pkg::USER_PC_MASK : '0;
        end
      end
      brms_pkg::KIND_RSAVED: begin
        if (act_bank != brms_pkg::BANK_USR) begin
          rd = spsr_rdata_i;
        end
      end
      brms_pkg::KIND_WSAVED: begin
        if (act_bank != brms_pkg::BANK_USR) begin
          wr.spsr_we   = 1'b1;
          wr.spsr_addr = spsr_raddr_o;
          wr.spsr_data = item_i.write_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit only when the item advances
  always_comb begin
    wr_o         = wr;
    wr_o.gpr_we  = wr.gpr_we & go_i;
    wr_o.spsr_we = wr.spsr_we & go_i;
    wr_o.pc_we   = wr.pc_we & go_i;
    wr_o.ctl_we  = go_i;
  end

  assign res_o.read_data    = rd;
  assign res_o.status_word  = wr.status;
  assign res_o.current_mode = wr.status[4:0];
  assign res_o.pc_mask      = wr.pc_mask;
  assign res_o.wide_mode    = wr.status[4];
  assign res_o.bad_mode     = bad;

endmodule

@@ sv/banked_register_mode_switch.sv @@
// Top level of the banked register file with mode switch and exception entry.
// Usage:
//   in_i  carries one access per transfer: register read/write, mode switch,
//         exception entry, status write, saved-status read/write.
//   out_o carries one result per access: read data, status word, mode,
//         PC mask, 32-bit flag and an undefined-mode flag.
// Flow: an access taken from in_i is executed from the input register, and
//   its result is registered into the output register when the access
//   advances; out_o presents it from that register.
// Throughput: one access per cycle while out_o does not stall; the state
//   update of each access is committed as it moves into the output register,
//   so the next access sees it straight away.
// Reset: the general registers, the PC, the status word, the saved statuses
//   and the PC mask clear to zero; the block comes up in mode 0 with the user bank.
// Stall: while out_o is held, the output register keeps its result, the
//   input register keeps one further access, and in_i drops ready.
`timescale 1ns / 1ps

module banked_register_mode_switch (
  input  logic          clk_i,
  input  logic          rst_ni,
  brms_stream_if.sink   in_i,
  brms_stream_if.source out_o
);

  logic                            in_valid_q;
  brms_pkg::brms_item_t            in_item_q;
  logic                            out_valid_q;
  brms_pkg::brms_result_t          out_res_q;
  logic                            advance;
  brms_pkg::brms_wr_t              wr;
  brms_pkg::brms_state_t           state;
  brms_pkg::brms_result_t          res;
  logic [brms_pkg::GPR_AW-1:0]     gpr_raddr;
  logic [brms_pkg::SPSR_AW-1:0]    spsr_raddr;
  logic [31:0]                     gpr_rdata;
  logic [31:0]                     spsr_rdata;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_res_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  brms_exec u_exec (
    .go_i         (advance),
    .item_i       (in_item_q),
    .state_i      (state),
    .gpr_rdata_i  (gpr_rdata),
    .spsr_rdata_i (spsr_rdata),
    .gpr_raddr_o  (gpr_raddr),
    .spsr_raddr_o (spsr_raddr),
    .wr_o         (wr),
    .res_o        (res)
  );

  brms_bank u_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .gpr_raddr_i  (gpr_raddr),
    .spsr_raddr_i (spsr_raddr),
    .gpr_rdata_o  (gpr_rdata),
    .spsr_rdata_o (spsr_rdata),
    .state_o      (state)
  );

`ifndef SYNTHESIS
  // Stored bank code stays within the defined banks
  a_bank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.bank <= brms_pkg::BANK_UND)
    else $error("bank select out of range");

  // PC mask is either clear or the user mask
  a_mask_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.pc_mask == '0 || state.pc_mask == brms_pkg::USER_PC_MASK)
    else $error("unexpected PC mask");

  // A valid exception entry yields a result with IRQ masked and no error
  a_exc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.kind == brms_pkg::KIND_EXC
     && in_item_q.exception_code <= brms_pkg::EXC_FIQ)
    |=> (out_valid_q && out_res_q.status_word[brms_pkg::IRQ_OFF_BIT]
         && !out_res_q.bad_mode))
    else $error("exception entry result wrong");

  // An access waiting on a stalled output stays in the input register
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)))
    else $error("pending access lost");
`endif

endmodule
